FILE: sv/aes128_block_encrypt_core_assert.svh
// Assertion macros for the AES-128 encryption core checker.
// Used by the checker file only; no other dependencies.
`ifndef AES128_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/aes_pkg.sv
// Package for the AES-128 encryption core: word types, S-box and round helpers.
// No dependencies.
package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned CfgIdxW    = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte n lives at bits [127-8n -: 8].
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Next round key from the previous one; rc is this round's constant.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(input int unsigned i);
    logic [7:0] r;
    r = 8'h01;
    for (int j = 0; j < 10; j++) begin
      if (j < i) r = xtime(r);
    end
    return r;
  endfunction

endpackage

FILE: sv/aes128_block_encrypt_core.sv
// AES-128 encryption core: one round per pipeline stage, key expanded alongside.
// Depends on aes_pkg.
//
//  channel | direction | handshake        | word
//  --------+-----------+------------------+---------------------------
//  cfg     | in        | valid / ready    | index, 64-bit key half
//  in      | in        | valid / stall    | aes_in_t plaintext block
//  out     | out       | valid / stall    | aes_out_t ciphertext block
//
// One block accepted per cycle while the output is not stalled; one stage for the
// initial key add, one per round; the last round stage drives the output.
// Each stage carries its own round key, so key writes affect only later blocks.
// Reset clears the valid bits and the two key-half registers, not the stage keys.
// A stall at the output while it holds a valid block freezes the whole pipeline; nothing is dropped.
module aes128_block_encrypt_core
  import aes_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = RoundCount
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [CfgIdxW:0] cfg_index_i,
  input  logic [63:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  aes_in_t        in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output aes_out_t       out_data_o
);

  logic [63:0] key_high_q, key_low_q;
  logic        adv;

  assign cfg_ready_o = 1'b1;
  // All stages advance together; only a held valid output word blocks them.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == {1'b0, CFG_KEY_HIGH}) key_high_q <= cfg_data_i;
      if (cfg_index_i == {1'b0, CFG_KEY_LOW})  key_low_q  <= cfg_data_i;
    end
  end

  // stage 0 holds the state after the initial key add; stage r after round r
  logic [127:0] st_q  [ROUND_COUNT+1];
  logic [127:0] key_q [ROUND_COUNT+1];
  logic         vld_q [ROUND_COUNT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ROUND_COUNT; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= ROUND_COUNT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      key_q[0] <= {key_high_q, key_low_q};
      st_q[0]  <= {in_data_i.plain_high, in_data_i.plain_low} ^ {key_high_q, key_low_q};
    end
  end

  for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
    logic [127:0] rk, ss;
    assign rk = next_key(key_q[r-1], rcon(r-1));
    assign ss = sub_shift(st_q[r-1]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        key_q[r] <= rk;
        st_q[r]  <= ((r == ROUND_COUNT) ? ss : mix_columns(ss)) ^ rk;
      end
    end
  end

  assign out_valid_o            = vld_q[ROUND_COUNT];
  assign out_data_o.cipher_high = st_q[ROUND_COUNT][127:64];
  assign out_data_o.cipher_low  = st_q[ROUND_COUNT][63:0];

endmodule

FILE: sv/aes_checker.sv
// Port-level checker for the AES-128 encryption core, bound to the core module.
// Depends on aes_pkg and aes128_block_encrypt_core_assert.svh.
`include "aes128_block_encrypt_core_assert.svh"

module aes_checker
  import aes_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input aes_out_t out_data_o
);

  `AES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled output word changed")
  `AES_ASSERT_IMP(a_stall_only_when_blocked, clk_i, rst_ni, in_stall_o,
    out_valid_o && out_stall_i, "input stalled without a held output word")
  `AES_ASSERT_IMP(a_no_stall_free_out, clk_i, rst_ni, !out_stall_i, !in_stall_o,
    "input stalled while output drains")

endmodule

bind aes128_block_encrypt_core aes_checker u_aes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: tb/testbench.sv
// Self-checking testbench for the AES-128 block encryption core.
// Depends on aes_pkg and aes128_block_encrypt_core; predicts each ciphertext word itself.
`timescale 1ns / 1ps

module testbench;
  import aes_pkg::*;

  localparam logic [CfgIdxW:0] IdxKeyHigh = {1'b0, CFG_KEY_HIGH};
  localparam logic [CfgIdxW:0] IdxKeyLow  = {1'b0, CFG_KEY_LOW};
  localparam logic [CfgIdxW:0] IdxSpareA  = 2'd2;
  localparam logic [CfgIdxW:0] IdxSpareB  = 2'd3;
  localparam int unsigned      IdleLimit  = 3000;
  localparam int unsigned      PipeDepth  = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW:0] cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  aes_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  aes_out_t    out_data_o;

  aes128_block_encrypt_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  typedef struct {
    logic [127:0] key;
    logic [127:0] plain;
    bit           known;
    logic [127:0] cipher;
  } vec_t;

  localparam logic [127:0] Ones = {128{1'b1}};

  vec_t vecs [10] = '{
    '{128'h0, 128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{128'h0, Ones, 1'b0, 128'h0},
    '{128'h0, 128'h80000000000000000000000000000001, 1'b0, 128'h0},
    '{128'h000102030405060708090a0b0c0d0e0f, 128'h00112233445566778899aabbccddeeff,
      1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{128'h000102030405060708090a0b0c0d0e0f, 128'h0, 1'b0, 128'h0},
    '{128'h2b7e151628aed2a6abf7158809cf4f3c, 128'h3243f6a8885a308d313198a2e0370734,
      1'b1, 128'h3925841d02dc09fbdc118597196a0b32},
    '{Ones, 128'h0, 1'b0, 128'h0},
    '{Ones, Ones, 1'b0, 128'h0},
    '{128'h80000000000000000000000000000001, {8{16'h55aa}}, 1'b0, 128'h0},
    '{128'h80000000000000000000000000000001, {8{16'haa55}}, 1'b0, 128'h0}
  };

  logic [7:0]   sub_lut [256];
  logic [127:0] cur_key;
  aes_out_t     cipher_q [$];
  aes_out_t     known_q  [$];
  bit           known_flag_q [$];
  int unsigned  errors;
  bit           hold_req;
  bit           send_burst;

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = mul2(a);
    end
    return p;
  endfunction

  // S-box from the field inverse and the affine map
  initial begin
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      b = inv;
      sub_lut[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                   ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
  end

  function automatic aes_out_t encrypt_block(input aes_in_t blk, input logic [127:0] key);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] rk [16];
    logic [7:0] rc, a0, a1, a2, a3, all;
    logic [127:0] res;
    rc = 8'h01;
    for (int n = 0; n < 16; n++) begin
      rk[n] = key[127-8*n -: 8];
      st[n] = blk[127-8*n -: 8] ^ rk[n];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[4*c+r] = sub_lut[st[4*((c+r)%4)+r]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ all ^ mul2(a0 ^ a1);
          tmp[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
          tmp[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
          tmp[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
        end
      end
      // next round key: rotated, substituted last column plus round constant
      rk[0] ^= sub_lut[rk[13]] ^ rc;
      rk[1] ^= sub_lut[rk[14]];
      rk[2] ^= sub_lut[rk[15]];
      rk[3] ^= sub_lut[rk[12]];
      for (int j = 4; j < 16; j++) rk[j] ^= rk[j-4];
      rc = mul2(rc);
      for (int n = 0; n < 16; n++) st[n] = tmp[n] ^ rk[n];
    end
    for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
    return res;
  endfunction

  // input side: predict every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) cipher_q.push_back(encrypt_block(in_data_i, cur_key));
  end

  // output side: compare with the oldest prediction
  always @(posedge clk_i) begin
    aes_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, out_data_o);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (known_flag_q.size() != 0) begin
          // typed-in vectors ride along in order with the directed words
          if (known_flag_q.pop_front()) want = known_q.pop_front();
        end
        if (out_data_o.cipher_high !== want.cipher_high) begin
          $display("%0t: cipher_high expected %h actual %h", $realtime,
                   want.cipher_high, out_data_o.cipher_high);
          errors++;
        end
        if (out_data_o.cipher_low !== want.cipher_low) begin
          $display("%0t: cipher_low expected %h actual %h", $realtime,
                   want.cipher_low, out_data_o.cipher_low);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    int unsigned idle_cnt;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= IdleLimit) begin
          $display("%0t: no progress for %0d cycles", $realtime, IdleLimit);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls, burst stretches, and one long hold
  initial begin
    bit burst;
    int unsigned left;
    out_stall_i = 1'b0;
    burst = 1'b0;
    left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else if (left > 0) begin
        left--;
      end else if ($urandom_range(0, 99) < 2) begin
        burst = !burst;
      end else if (!burst && $urandom_range(0, 99) < 3) begin
        out_stall_i = 1'b1;
        left = $urandom_range(8, 40);
      end else begin
        out_stall_i = !burst && ($urandom_range(0, 99) < 30);
      end
    end
  end

  function automatic int unsigned send_gap();
    int unsigned r;
    if (send_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_block(input aes_in_t blk);
    int unsigned g;
    @(negedge clk_i);
    in_data_i  = blk;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    g = send_gap();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (cipher_q.size() == 0);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == IdxKeyHigh) cur_key[127:64] = val;
    else if (idx == IdxKeyLow) cur_key[63:0] = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_key(input logic [127:0] key);
    drain();
    write_reg(IdxKeyHigh, key[127:64]);
    write_reg(IdxKeyLow, key[63:0]);
  endtask

  initial begin
    logic [127:0] phase_key;
    errors      = 0;
    hold_req    = 1'b0;
    send_burst  = 1'b0;
    cur_key     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = IdxKeyHigh;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // writes past the register list must leave the reset key alone
    write_reg(IdxSpareA, {64{1'b1}});
    write_reg(IdxSpareB, 64'h0123456789abcdef);

    foreach (vecs[i]) begin
      if (vecs[i].key !== cur_key) load_key(vecs[i].key);
      known_flag_q.push_back(vecs[i].known);
      if (vecs[i].known) known_q.push_back(vecs[i].cipher);
      send_block(vecs[i].plain);
    end
    drain();
    known_flag_q.delete();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1:       phase_key = Ones;
        3:       phase_key = '0;
        default: phase_key = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_key(phase_key);
      write_reg(ph[0] ? IdxSpareA : IdxSpareB, {$urandom, $urandom});
      send_burst = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if (ph == 4 && n == 50) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          wait (cipher_q.size() == 0);
        end
        send_block({$urandom, $urandom, $urandom, $urandom});
      end
    end
    send_burst = 1'b0;

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (cipher_q.size() == 0);
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/aes_pkg.sv
sv/aes128_block_encrypt_core.sv
sv/aes_checker.sv
tb/testbench.sv
